// ===== src/nearest_path_point_search_core_macros.svh =====
// Assertion macros shared by the checkers of the nearest point search core.
// Self-contained; no dependencies.
`ifndef NEAREST_PATH_POINT_SEARCH_CORE_MACROS_SVH
`define NEAREST_PATH_POINT_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NPPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NPPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/npps_pkg.sv =====
// Types and constants of the nearest path point search core.
// No dependencies; used by npps_dist, the top level and the checker.
package npps_pkg;

    localparam int IDX_W      = 10;
    localparam int COORD_W    = 32;
    localparam int LEN_W      = 32;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 1;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PATH_POINT_COUNT = 2'd0;
    localparam t_cfg_idx CFG_WINDOW_RANGE     = 2'd1;
    localparam t_cfg_idx CFG_PERMIT_ERROR     = 2'd2;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [LEN_W-1:0]   len;
    } t_point;

    localparam int POINT_W = 2 * COORD_W + LEN_W;

    // Sideband that travels with each read through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LO     = 7'b0000010,
        S_HI     = 7'b0000100,
        S_WIN    = 7'b0001000,
        S_DECIDE = 7'b0010000,
        S_FULL   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

endpackage

// ===== src/npps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module npps_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/npps_dist.sv =====
// Three-stage squared distance pipeline: abs difference, square, sum.
// Depends on npps_pkg.
module npps_dist #(
    parameter int AW = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  npps_pkg::t_tag                      i_tag,
    input  logic [AW-1:0]                       i_index,
    input  npps_pkg::t_point                    i_point,
    input  logic signed [npps_pkg::COORD_W-1:0] i_pose_x,
    input  logic signed [npps_pkg::COORD_W-1:0] i_pose_y,
    output npps_pkg::t_tag                      o_tag,
    output logic [AW-1:0]                       o_index,
    output logic [npps_pkg::DIST_W-1:0]         o_dist
);

    localparam int CW = npps_pkg::COORD_W;
    localparam int SW = npps_pkg::SQ_W;

    npps_pkg::t_tag r_tag1, r_tag2, r_tag3;
    logic [AW-1:0]  r_idx1, r_idx2, r_idx3;
    logic [CW-1:0]  r_dx, r_dy;
    logic [SW-1:0]  r_sx, r_sy;
    logic [npps_pkg::DIST_W-1:0] r_dist;

    logic signed [CW:0] w_dx_s, w_dy_s;
    logic        [CW:0] w_dx_a, w_dy_a;
    logic [SW-1:0]      w_sx, w_sy;

    // |pose - point| never exceeds 2^32 - 1, so the magnitude fits CW bits.
    assign w_dx_s = {i_pose_x[CW-1], i_pose_x} - {i_point.x[CW-1], i_point.x};
    assign w_dy_s = {i_pose_y[CW-1], i_pose_y} - {i_point.y[CW-1], i_point.y};
    assign w_dx_a = w_dx_s[CW] ? -w_dx_s : w_dx_s;
    assign w_dy_a = w_dy_s[CW] ? -w_dy_s : w_dy_s;
    assign w_sx   = r_dx * r_dx;
    assign w_sy   = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_index;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_dx   <= w_dx_a[CW-1:0];
        r_dy   <= w_dy_a[CW-1:0];
        r_sx   <= w_sx;
        r_sy   <= w_sy;
        r_dist <= {1'b0, r_sx} + {1'b0, r_sy};
    end

    assign o_tag   = r_tag3;
    assign o_index = r_idx3;
    assign o_dist  = r_dist;

endmodule

// ===== src/nearest_path_point_search_core.sv =====
// A load item is written in its accept cycle; a query walks and scans a window when one is enabled,
// and runs a full search of the N points in use when no window runs or its result is rejected.
// Throughput: one item at a time; the single read port of the point RAM, read once per
// cycle by the window walk and the scans, sets the query time.
// Reset: synchronous active-low; clears control and configuration, not the point RAM.
//
// Top level of the nearest path point search. Depends on npps_pkg, npps_ram, npps_dist.
module nearest_path_point_search_core #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  npps_pkg::t_cfg_idx                     i_cfg_index,
    input  logic [npps_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_mode,
    input  logic [npps_pkg::IDX_W-1:0]             i_point_index,
    input  logic signed [npps_pkg::COORD_W-1:0]    i_point_x,
    input  logic signed [npps_pkg::COORD_W-1:0]    i_point_y,
    input  logic [npps_pkg::LEN_W-1:0]             i_point_remaining_length,
    input  logic signed [npps_pkg::COORD_W-1:0]    i_pose_x,
    input  logic signed [npps_pkg::COORD_W-1:0]    i_pose_y,
    input  logic                                   i_prev_valid,
    input  logic [npps_pkg::IDX_W-1:0]             i_prev_index,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [npps_pkg::IDX_W-1:0]             o_nearest_index,
    output logic                                   o_full_search_used
);

    // Index width into the point RAM, and a count width wide enough for both the
    // configured count and MAX_POINTS itself.
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = (AW + 1 > npps_pkg::CNT_W) ? AW + 1 : npps_pkg::CNT_W;
    localparam int LW = npps_pkg::LEN_W;
    localparam int DW = npps_pkg::DIST_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [npps_pkg::CNT_W-1:0] r_count;
    logic [LW-1:0]              r_range;
    logic [LW-1:0]              r_permit;
    logic [npps_pkg::SQ_W-1:0]  r_pe;      // permit_error squared

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= npps_pkg::CNT_W'(1);
            r_range  <= '0;
            r_permit <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                npps_pkg::CFG_PATH_POINT_COUNT: begin
                    r_count <= i_cfg_wdata[npps_pkg::CNT_W-1:0];
                end
                npps_pkg::CFG_WINDOW_RANGE: begin
                    r_range <= i_cfg_wdata[LW-1:0];
                end
                npps_pkg::CFG_PERMIT_ERROR: begin
                    r_permit <= i_cfg_wdata[LW-1:0];
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Config must only change while idle (the block itself does not enforce it), so the free-running
    // square is always settled long before a query reaches its permit check.
    always_ff @(posedge i_clk) begin
        r_pe <= r_permit * r_permit;
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    npps_pkg::t_state r_state, n_state;

    logic signed [npps_pkg::COORD_W-1:0] r_px, n_px, r_py, n_py;
    logic [AW-1:0] r_p, n_p;          // saturated previous index
    logic [AW-1:0] r_last, n_last;    // last point in use
    logic [AW-1:0] r_lo, n_lo;        // lower window edge
    logic [AW-1:0] r_addr, n_addr;    // next read address
    logic [AW-1:0] r_end, n_end;      // upper bound of the current sweep
    logic          r_iss, n_iss;      // issuing reads
    logic          r_rv, n_rv;        // read data valid this cycle
    logic [AW-1:0] r_ra, n_ra;        // address of the read data
    logic          r_rlast, n_rlast;  // read data is the last of a scan
    logic          r_rfirst, n_rfirst;// read data is the reference point
    logic [LW-1:0] r_ref, n_ref;      // remaining length at the previous index
    logic          r_have, n_have;    // tracker holds a candidate
    logic [DW-1:0] r_best, n_best;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic          r_full, n_full;

    logic                 r_out_valid, n_out_valid;
    npps_pkg::t_idx       r_out_idx, n_out_idx;
    logic                 r_out_full, n_out_full;

    // ------------------------------------------------------------------
    // Point memory: x, y and remaining length packed in one word
    // ------------------------------------------------------------------
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    npps_pkg::t_point              w_wpoint;
    logic [npps_pkg::POINT_W-1:0]  w_rdata;
    npps_pkg::t_point              w_rd;

    npps_ram #(
        .WIDTH (npps_pkg::POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wpoint),
        .i_re    (r_iss),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_rd = w_rdata;

    // ------------------------------------------------------------------
    // Distance pipeline and argmin tracker
    // ------------------------------------------------------------------
    npps_pkg::t_tag   w_dtag_in, w_dtag;
    logic [AW-1:0]    w_didx;
    logic [DW-1:0]    w_dist;
    logic             w_scan, w_trk_done;

    assign w_scan          = (r_state == npps_pkg::S_WIN) || (r_state == npps_pkg::S_FULL);
    assign w_dtag_in.valid = r_rv && w_scan;
    assign w_dtag_in.last  = r_rlast;

    npps_dist #(
        .AW (AW)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_dtag_in),
        .i_index  (r_ra),
        .i_point  (w_rd),
        .i_pose_x (r_px),
        .i_pose_y (r_py),
        .o_tag    (w_dtag),
        .o_index  (w_didx),
        .o_dist   (w_dist)
    );

    assign w_trk_done = w_dtag.valid && w_dtag.last;

    // ------------------------------------------------------------------
    // Input decode: count saturation, previous index clamp, load slot check
    // ------------------------------------------------------------------
    logic          w_in_acc, w_out_acc;
    logic [CW-1:0] w_cnt0, w_cnt, w_last_ext, w_prev_ext, w_slot_ext;
    logic [AW-1:0] w_last, w_p;
    logic          w_slot_ok;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;

    assign w_cnt0     = (r_count == '0) ? CW'(1) : CW'(r_count);
    assign w_cnt      = (w_cnt0 > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : w_cnt0;
    assign w_last_ext = w_cnt - CW'(1);
    assign w_last     = w_last_ext[AW-1:0];
    assign w_prev_ext = CW'(i_prev_index);
    assign w_p        = (w_prev_ext > w_last_ext) ? w_last : w_prev_ext[AW-1:0];
    assign w_slot_ext = CW'(i_point_index);
    assign w_slot_ok  = w_slot_ext < CW'(MAX_POINTS);

    // Loads write straight through in the accept cycle.
    assign w_we         = w_in_acc && (i_mode == npps_pkg::MODE_LOAD) && w_slot_ok;
    assign w_waddr      = w_slot_ext[AW-1:0];
    assign w_wpoint.x   = i_point_x;
    assign w_wpoint.y   = i_point_y;
    assign w_wpoint.len = i_point_remaining_length;

    // ------------------------------------------------------------------
    // Window walk: gap of the returned length against the reference
    // ------------------------------------------------------------------
    logic [LW-1:0] w_ref_len, w_gap;
    logic          w_far;

    assign w_ref_len = r_rfirst ? w_rd.len : r_ref;
    assign w_gap     = (w_rd.len > w_ref_len) ? (w_rd.len - w_ref_len)
                                              : (w_ref_len - w_rd.len);
    assign w_far     = w_gap > r_range;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_px        = r_px;
        n_py        = r_py;
        n_p         = r_p;
        n_last      = r_last;
        n_lo        = r_lo;
        n_addr      = r_addr;
        n_end       = r_end;
        n_iss       = r_iss;
        n_ref       = r_ref;
        n_have      = r_have;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_full      = r_full;
        n_out_valid = r_out_valid && !w_out_acc;
        n_out_idx   = r_out_idx;
        n_out_full  = r_out_full;

        // Read tags are registered alongside the RAM's registered read data.
        n_rv     = r_iss;
        n_ra     = r_addr;
        n_rlast  = (r_addr == r_end);
        n_rfirst = (r_state == npps_pkg::S_LO) && (r_addr == r_p);

        // Advance the read address; the lower walk runs downward.
        if (r_iss) begin
            if (r_state == npps_pkg::S_LO) begin
                if (r_addr == '0) begin
                    n_iss = 1'b0;
                end else begin
                    n_addr = r_addr - AW'(1);
                end
            end else begin
                if (r_addr == r_end) begin
                    n_iss = 1'b0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
        end

        // Keep the first of the smallest distances: scans run upward.
        if (w_dtag.valid) begin
            n_have = 1'b1;
            if (!r_have || (w_dist < r_best)) begin
                n_best     = w_dist;
                n_best_idx = w_didx;
            end
        end

        unique case (r_state)
            npps_pkg::S_IDLE: begin
                if (w_in_acc && (i_mode == npps_pkg::MODE_QUERY)) begin
                    n_px   = i_pose_x;
                    n_py   = i_pose_y;
                    n_p    = w_p;
                    n_last = w_last;
                    n_full = 1'b0;
                    if ((r_range != '0) && i_prev_valid) begin
                        n_state = npps_pkg::S_LO;
                        n_addr  = w_p;
                        n_iss   = 1'b1;
                    end else begin
                        n_state = npps_pkg::S_FULL;
                        n_addr  = '0;
                        n_end   = w_last;
                        n_iss   = 1'b1;
                        n_have  = 1'b0;
                        n_full  = 1'b1;
                    end
                end
            end
            npps_pkg::S_LO: begin
                if (r_rv) begin
                    if (r_rfirst) begin
                        n_ref = w_rd.len;
                    end
                    // Stop at index zero or at the first point out of range (kept).
                    if ((r_ra == '0) || w_far) begin
                        n_lo    = r_ra;
                        n_state = npps_pkg::S_HI;
                        n_addr  = r_p;
                        n_end   = r_last;
                        n_iss   = 1'b1;
                        n_rv    = 1'b0;
                    end
                end
            end
            npps_pkg::S_HI: begin
                if (r_rv && ((r_ra == r_last) || w_far)) begin
                    n_state = npps_pkg::S_WIN;
                    n_addr  = r_lo;
                    n_end   = r_ra;
                    n_iss   = 1'b1;
                    n_rv    = 1'b0;
                    n_have  = 1'b0;
                end
            end
            npps_pkg::S_WIN: begin
                if (w_trk_done) begin
                    n_state = npps_pkg::S_DECIDE;
                end
            end
            npps_pkg::S_DECIDE: begin
                // Reject the window result when it lies beyond the permit error.
                if (r_best > {1'b0, r_pe}) begin
                    n_state = npps_pkg::S_FULL;
                    n_addr  = '0;
                    n_end   = r_last;
                    n_iss   = 1'b1;
                    n_have  = 1'b0;
                    n_full  = 1'b1;
                end else begin
                    n_state = npps_pkg::S_OUT;
                end
            end
            npps_pkg::S_FULL: begin
                if (w_trk_done) begin
                    n_state = npps_pkg::S_OUT;
                end
            end
            npps_pkg::S_OUT: begin
                // Hold until the output register is free or being taken.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = npps_pkg::t_idx'(r_best_idx);
                    n_out_full  = r_full;
                    n_state     = npps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = npps_pkg::S_IDLE;
                n_iss   = 1'b0;
                n_rv    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npps_pkg::S_IDLE;
            r_iss       <= 1'b0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iss       <= n_iss;
            r_rv        <= n_rv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px       <= n_px;
        r_py       <= n_py;
        r_p        <= n_p;
        r_last     <= n_last;
        r_lo       <= n_lo;
        r_addr     <= n_addr;
        r_end      <= n_end;
        r_ra       <= n_ra;
        r_rlast    <= n_rlast;
        r_rfirst   <= n_rfirst;
        r_ref      <= n_ref;
        r_have     <= n_have;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_full     <= n_full;
        r_out_idx  <= n_out_idx;
        r_out_full <= n_out_full;
    end

    assign o_in_stall         = (r_state != npps_pkg::S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_nearest_index    = r_out_idx;
    assign o_full_search_used = r_out_full;

endmodule

// ===== src/npps_chk.sv =====
// Port-level checker for the nearest path point search core, bound to the top level.
// Depends on npps_pkg and nearest_path_point_search_core_macros.svh.
`include "nearest_path_point_search_core_macros.svh"

module npps_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_we,
    input npps_pkg::t_cfg_idx                  i_cfg_index,
    input logic [npps_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                i_mode,
    input logic [npps_pkg::IDX_W-1:0]          i_point_index,
    input logic signed [npps_pkg::COORD_W-1:0] i_point_x,
    input logic signed [npps_pkg::COORD_W-1:0] i_point_y,
    input logic [npps_pkg::LEN_W-1:0]          i_point_remaining_length,
    input logic signed [npps_pkg::COORD_W-1:0] i_pose_x,
    input logic signed [npps_pkg::COORD_W-1:0] i_pose_y,
    input logic                                i_prev_valid,
    input logic [npps_pkg::IDX_W-1:0]          i_prev_index,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [npps_pkg::IDX_W-1:0]          o_nearest_index,
    input logic                                o_full_search_used
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // A stalled result keeps its item.
    `NPPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_nearest_index) && $stable(o_full_search_used), "stalled result changed")

    // A query always occupies the block past its accept cycle.
    `NPPS_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, w_in_acc && (i_mode == npps_pkg::MODE_QUERY), o_in_stall, "query did not stall the input")

    // A load accepted with no result pending does not produce one.
    `NPPS_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, w_in_acc && (i_mode == npps_pkg::MODE_LOAD) && !o_out_valid, !o_out_valid, "load produced a result")

    // A new result appears exactly as the block returns to idle.
    `NPPS_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, $rose(o_out_valid), !o_in_stall && $past(o_in_stall), "result without end of query")

endmodule

bind nearest_path_point_search_core npps_chk u_npps_chk (.*);
